[rtl/fma_pkg.sv]
package fma_pkg;

    localparam int MAX_BINS_DEF = 1024;
    localparam int MAG_W = 40;
    localparam int DIV_W = 16;
    localparam int DATA_W = 32;
    localparam int SQ_W = 64;
    localparam int ROOT_STEPS = 40;
    localparam int DIVQ_W = 56;

    localparam logic [1:0] REG_LOG2_LENGTH = 2'd0;
    localparam logic [1:0] REG_SUPPRESS_DC = 2'd1;
    localparam logic [1:0] REG_NUM_AVERAGE = 2'd2;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef struct packed {
        logic load;
        logic sq_step;
        logic root_step;
        logic mul_step;
        logic div_step;
        logic store_rd;
        logic store_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic clear_busy;
    } t_status;

endpackage

[rtl/fma_ctrl.sv]
module fma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_free,
    input  fma_pkg::t_status i_status,
    output fma_pkg::t_cmd    o_cmd
);
    import fma_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_ROOT = 7'b0000100,
        S_RD   = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_status.clear_busy;
                if (i_in_valid && !i_status.clear_busy) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.store_rd = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.store_wr = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/fma_dp.sv]
module fma_dp #(
    parameter int MAX_BINS = fma_pkg::MAX_BINS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [fma_pkg::DIV_W-1:0]  i_cfg_data,
    input  fma_pkg::t_cmd              i_cmd,
    output fma_pkg::t_status           o_status,
    input  logic [fma_pkg::DATA_W-1:0] i_re,
    input  logic [fma_pkg::DATA_W-1:0] i_im,
    input  logic                       i_last,
    input  logic                       i_restart,
    output logic [fma_pkg::MAG_W-1:0]  o_avg,
    output logic [fma_pkg::DATA_W-1:0] o_re,
    output logic [fma_pkg::DATA_W-1:0] o_im,
    output logic                       o_last,
    output logic [fma_pkg::DIV_W-1:0]  o_div
);
    import fma_pkg::*;

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [MAG_W-1:0] mem [MAX_BINS];
    logic [MAG_W-1:0] r_rd;

    logic [4:0]       r_log2;
    logic             r_sdc;
    logic [DIV_W-1:0] r_navg;
    logic             r_pend;
    logic [DIV_W-1:0] r_fdiv, r_next;
    logic [CNT_W-1:0] r_bin;
    logic             r_clr;
    logic [IDX_W-1:0] r_clr_idx;

    logic [DATA_W-1:0] r_re, r_im;
    logic              r_last;
    logic [DATA_W-1:0] r_are, r_aim;
    logic [SQ_W-1:0]   r_s;
    logic [MAG_W-1:0]  r_root;
    logic [MAG_W+2:0]  r_rem;
    logic [5:0]        r_cnt;
    logic [MAG_W-1:0]  r_mag;
    logic [DIVQ_W-1:0] r_num;
    logic [DIVQ_W-1:0] r_quo;
    logic [DIVQ_W:0]   r_drem;

    logic [DIV_W-1:0] w_limit, w_d;
    logic             w_first, w_inrange;
    logic [DATA_W-1:0] w_re, w_im;
    logic [1:0]        w_pair;
    logic [MAG_W+2:0]  w_rem2, w_trial;
    logic [DIVQ_W:0]   w_dsh;
    logic [MAG_W-1:0]  w_mag;

    assign w_first = (r_bin == '0);
    assign w_inrange = (r_bin < CNT_W'(MAX_BINS));
    assign w_limit = (r_navg == '0) ? DIV_W'(1) : r_navg;
    assign w_d = (r_pend || i_restart) ? DIV_W'(1) : r_next;
    assign w_re = (w_first && r_sdc) ? '0 : i_re;
    assign w_im = (w_first && r_sdc) ? '0 : i_im;
    assign o_status.root_done = (r_cnt == 6'(ROOT_STEPS - 1));
    assign o_status.div_done = (r_cnt == 6'(DIVQ_W - 1));
    assign o_status.clear_busy = r_clr;

    // One result bit per step of the root, over the 64-bit sum then 8 zero pairs.
    assign w_pair = (r_cnt < 6'd32) ? r_s[SQ_W-1 -: 2] : 2'b00;
    assign w_rem2 = {r_rem[MAG_W:0], w_pair};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_dsh = {r_drem[DIVQ_W-1:0], r_num[DIVQ_W-1]};
    assign w_mag = r_root >> r_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= 5'd10;
            r_sdc <= 1'b0;
            r_navg <= DIV_W'(1);
            r_pend <= 1'b1;
            r_fdiv <= DIV_W'(1);
            r_next <= DIV_W'(1);
            r_bin <= '0;
            r_clr <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(MAX_BINS - 1)) r_clr <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_LOG2_LENGTH: begin
                        if (i_cfg_data[4:0] != r_log2) begin
                            r_clr <= 1'b1;
                            r_clr_idx <= '0;
                        end
                        r_log2 <= i_cfg_data[4:0];
                    end
                    REG_SUPPRESS_DC: r_sdc <= i_cfg_data[0];
                    REG_NUM_AVERAGE: begin
                        if (i_cfg_data != r_navg) r_pend <= 1'b1;
                        r_navg <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (w_first) begin
                    r_pend <= 1'b0;
                    r_fdiv <= w_d;
                    r_next <= (w_d < w_limit) ? w_d + 1'b1 : w_d;
                end
                if (i_last) r_bin <= '0;
                else if (w_inrange) r_bin <= r_bin + 1'b1;
            end
        end
    end

    // The bin index was advanced at load, so the datapath keeps its own copy.
    logic [IDX_W-1:0] r_idx;
    logic             r_valid_idx;

    always_ff @(posedge i_clk) begin
        if (r_clr) mem[r_clr_idx] <= '0;
        else if (i_cmd.store_wr && r_valid_idx) mem[r_idx] <= r_quo[MAG_W-1:0];
        if (i_cmd.store_rd) r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re <= w_re;
            r_im <= w_im;
            r_last <= i_last;
            r_are <= w_re[DATA_W-1] ? -w_re : w_re;
            r_aim <= w_im[DATA_W-1] ? -w_im : w_im;
            r_idx <= r_bin[IDX_W-1:0];
            r_valid_idx <= w_inrange;
        end
        if (i_cmd.sq_step) begin
            r_s <= r_are * r_are + r_aim * r_aim;
            r_root <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.root_step) begin
            r_s <= r_s << 2;
            r_cnt <= r_cnt + 1'b1;
            if (w_rem2 >= w_trial) begin
                r_rem <= w_rem2 - w_trial;
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2;
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.store_rd) r_mag <= w_mag;
        if (i_cmd.mul_step) begin
            r_num <= DIVQ_W'(r_rd) * DIVQ_W'(r_fdiv - 1'b1) + DIVQ_W'(r_mag);
            r_drem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_num <= r_num << 1;
            if (w_dsh >= (DIVQ_W+1)'(r_fdiv)) begin
                r_drem <= w_dsh - (DIVQ_W+1)'(r_fdiv);
                r_quo <= {r_quo[DIVQ_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dsh;
                r_quo <= {r_quo[DIVQ_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            o_avg <= r_valid_idx ? r_quo[MAG_W-1:0] : '0;
            o_re <= r_re;
            o_im <= r_im;
            o_last <= r_last;
            o_div <= r_fdiv;
        end
    end
endmodule

[rtl/fft_magnitude_averager_top.sv]
// One bin is taken per beat and gives one result beat. A bin passes through
// load, square, the bit-serial square root, store read, multiply, the restoring
// divider that forms the running average, and output. After reset and after
// every change of log2_length the store of MAX_BINS averages is cleared, one
// entry per cycle, and no bin is accepted while it clears. The output register
// holds one result, so a new bin is taken while the last result waits.
module fft_magnitude_averager_top #(
    parameter int MAX_BINS = fma_pkg::MAX_BINS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // real_part, imag_part
    input  logic         s_axis_tlast,  // last_bin
    input  logic         s_axis_tuser,  // restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // average_magnitude, real_out, imag_out, frames_averaged
    output logic         m_axis_tlast   // frame_end
);
    import fma_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    r_ovalid;
    logic [MAG_W-1:0]  w_avg;
    logic [DATA_W-1:0] w_re, w_im;
    logic [DIV_W-1:0]  w_div;
    logic              w_last;

    fma_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    fma_dp #(.MAX_BINS(MAX_BINS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_re(s_axis_tdata[31:0]), .i_im(s_axis_tdata[63:32]),
        .i_last(s_axis_tlast), .i_restart(s_axis_tuser),
        .o_avg(w_avg), .o_re(w_re), .o_im(w_im), .o_last(w_last), .o_div(w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_cmd.out_load) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {w_div, w_im, w_re, w_avg};
    assign m_axis_tlast = w_last;
endmodule

[rtl/fma_checker.sv]
module fma_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    // A bin takes many cycles, so ready drops right after an accepted beat.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast)) else $error("output not held");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[119:104] != 16'd0)
        else $error("bad divisor");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind fft_magnitude_averager_top fma_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
